@@ design/ckt_pkg.sv @@
// ----------------------------------------------------------------------------
// ckt_pkg: shared types and constants of the command keyword tokenizer
// Request and token structs, token kinds, keyword tables and helpers.
// ----------------------------------------------------------------------------
package ckt_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] KIND_END   = 4'd0;
  localparam logic [3:0] KIND_PATH  = 4'd7;
  localparam logic [3:0] KIND_UNSUP = 4'd8;

  localparam logic [7:0] PATH_MARK = 8'h40;

  // Tail of the first keyword, eleven ASCII bytes, first byte at the top.
  localparam logic [87:0] KW0_TAIL = 88'h636c61726974795f636d64;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  // One or two tokens caused by one request.
  typedef struct packed {
    out_item_t tok0;
    out_item_t tok1;
    logic      two;
  } run_t;

  // Low 16 bits of an offset, zero-extended where offsets are narrower.
  function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

  function automatic out_item_t mk_tok(input logic [3:0] kind,
                                       input logic [OFFSET_BITS-1:0] start,
                                       input logic [OFFSET_BITS-1:0] len);
    out_item_t t;
    t.token_kind   = kind;
    t.token_start  = to16(start);
    t.token_length = to16(len);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Zero-based keyword number from its first letter.
  function automatic logic [3:0] kw_first(input logic [7:0] b);
    logic [3:0] r;
    case (b)
      "p":     r = {1'b1, 3'd0};
      "r":     r = {1'b1, 3'd1};
      "q":     r = {1'b1, 3'd2};
      "s":     r = {1'b1, 3'd3};
      "t":     r = {1'b1, 3'd4};
      "u":     r = {1'b1, 3'd5};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] id);
    logic [3:0] l;
    case (id)
      3'd0:    l = 4'd11;
      3'd1:    l = 4'd5;
      3'd2:    l = 4'd3;
      3'd3:    l = 4'd7;
      3'd4:    l = 4'd4;
      3'd5:    l = 4'd6;
      default: l = 4'd11;
    endcase
    return l;
  endfunction

  // Byte idx of the tail of keyword id (idx below the tail length).
  function automatic logic [7:0] kw_tail(input logic [2:0] id, input logic [3:0] idx);
    logic [87:0] s;
    logic [3:0]  off;
    case (id)
      3'd0:    s = KW0_TAIL;
      3'd1:    s = 88'("eport");
      3'd2:    s = 88'("uit");
      3'd3:    s = 88'("hutdown");
      3'd4:    s = 88'("rack");
      3'd5:    s = 88'("ntrack");
      default: s = KW0_TAIL;
    endcase
    off = kw_len(id) - 4'd1 - idx;
    return s[{off, 3'b000} +: 8];
  endfunction

endpackage

@@ design/ckt_front.sv @@
// ----------------------------------------------------------------------------
// ckt_front: lexer front end
// Accepts one request per cycle unless full, steps lexer state, forms the run.
// ----------------------------------------------------------------------------
module ckt_front
  import ckt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     in_full,
  output logic     q_push,
  output run_t     q_run
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_KEYWORD = 2'd1;
  localparam logic [1:0] PH_PATH    = 2'd2;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [1:0]             phase_r, phase_nxt;
  logic [2:0]             kw_id_r, kw_id_nxt;
  logic [3:0]             match_r, match_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [3:0]             first;
  logic                   ws;

  // Idle handling of the byte, starting from the current position
  logic                   idle_emit;
  out_item_t              idle_tok;
  logic [1:0]             idle_phase;
  logic [2:0]             idle_kw;
  logic [3:0]             idle_match;
  logic [OFFSET_BITS-1:0] idle_start;

  // Keyword matching
  logic [2:0]             kid;
  logic [3:0]             klen;
  logic [3:0]             kidx;
  logic [4:0]             kidx_inc;

  logic [1:0]             n;
  out_item_t              tok0, tok1;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign b       = in_item.data_byte;
  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign first   = kw_first(b);
  assign ws      = is_space(b);

  always_comb begin
    idle_emit  = 1'b0;
    idle_phase = PH_IDLE;
    idle_kw    = kw_id_r;
    idle_match = match_r;
    idle_start = ws ? start_r : pos_r;
    idle_tok   = mk_tok((b == 8'h00) ? KIND_END : KIND_UNSUP, pos_r, pos_inc - pos_r);
    if (!ws) begin
      if (b == 8'h00) begin
        idle_emit = 1'b1;
      end else if (first[3]) begin
        idle_phase = PH_KEYWORD;
        idle_kw    = first[2:0] + 3'd1;
        idle_match = 4'd0;
      end else if (b == PATH_MARK) begin
        idle_phase = PH_PATH;
      end else begin
        idle_emit = 1'b1;
      end
    end
  end

  assign kid      = ((kw_id_r >= 3'd1) && (kw_id_r <= 3'd6)) ? kw_id_r - 3'd1 : 3'd0;
  assign klen     = kw_len(kid);
  assign kidx     = (match_r < klen) ? match_r : klen - 4'd1;
  assign kidx_inc = {1'b0, kidx} + 5'd1;

  always_comb begin
    phase_nxt = phase_r;
    kw_id_nxt = kw_id_r;
    match_nxt = match_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    n         = 2'd0;
    tok0      = mk_tok(KIND_UNSUP, start_r, pos_r - start_r);
    tok1      = mk_tok(KIND_END, pos_r, '0);
    if (in_item.mode) begin
      phase_nxt = PH_IDLE;
      if (phase_r == PH_KEYWORD || phase_r == PH_PATH) begin
        n = 2'd2;
      end else begin
        tok0 = mk_tok(KIND_END, pos_r, '0);
        n    = 2'd1;
      end
    end else begin
      case (phase_r)
        PH_KEYWORD: begin
          if (b == kw_tail(kid, kidx)) begin
            pos_nxt   = pos_inc;
            match_nxt = kidx_inc[3:0];
            if (kidx_inc >= {1'b0, klen}) begin
              phase_nxt = PH_IDLE;
              tok0      = mk_tok({1'b0, kid} + 4'd1, start_r, pos_inc - start_r);
              n         = 2'd1;
            end
          end else begin
            // Drop the prefix as unsupported, then treat the byte as idle.
            phase_nxt = idle_phase;
            kw_id_nxt = idle_kw;
            match_nxt = idle_match;
            start_nxt = idle_start;
            pos_nxt   = pos_inc;
            tok1      = idle_tok;
            n         = idle_emit ? 2'd2 : 2'd1;
          end
        end
        PH_PATH: begin
          pos_nxt = pos_inc;
          if (b == PATH_MARK) begin
            phase_nxt = PH_IDLE;
            tok0      = mk_tok(KIND_PATH, start_r, pos_inc - start_r);
            n         = 2'd1;
          end
        end
        default: begin
          phase_nxt = idle_phase;
          kw_id_nxt = idle_kw;
          match_nxt = idle_match;
          start_nxt = idle_start;
          pos_nxt   = pos_inc;
          tok0      = idle_tok;
          n         = idle_emit ? 2'd1 : 2'd0;
        end
      endcase
    end
    tok0.last_of_run = (n == 2'd1);
    tok1.last_of_run = 1'b1;
  end

  assign q_push   = accept && (n != 2'd0);
  assign q_run.tok0 = tok0;
  assign q_run.tok1 = tok1;
  assign q_run.two  = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kw_id_r <= '0;
      match_r <= '0;
      start_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kw_id_r <= kw_id_nxt;
      match_r <= match_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

@@ design/ckt_queue.sv @@
// ----------------------------------------------------------------------------
// ckt_queue: run queue between front and back
// Small first-in first-out store of runs of one or two tokens.
// ----------------------------------------------------------------------------
module ckt_queue
  import ckt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t wr_run,
  output logic full,
  input  logic pop,
  output logic empty,
  output run_t rd_run
);

  run_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_run  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/ckt_back.sv @@
// ----------------------------------------------------------------------------
// ckt_back: token output stage
// Holds one run in an output register and hands out its tokens in order.
// ----------------------------------------------------------------------------
module ckt_back
  import ckt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  run_t      q_run,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  run_t run_r;
  logic valid_r;
  logic sel_r;
  logic taken;
  logic run_done;

  assign taken     = out_pop && valid_r;
  assign run_done  = !valid_r || (taken && (sel_r || !run_r.two));
  assign q_pop     = run_done && !q_empty;
  assign out_empty = !valid_r;
  assign out_item  = sel_r ? run_r.tok1 : run_r.tok0;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      run_r <= q_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (run_done) begin
      valid_r <= !q_empty;
      sel_r   <= 1'b0;
    end else if (taken) begin
      sel_r <= 1'b1;
    end
  end

endmodule

@@ design/command_keyword_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// command_keyword_tokenizer_top: byte-serial command keyword tokenizer
// Splits a text stream into keyword, path, unsupported and end tokens.
// ----------------------------------------------------------------------------
// Input channel: a queue-like port. Drive in_item and raise in_push; the
// request is taken at a clock edge where in_full is low. in_item.mode = 0
// carries one text byte, mode = 1 closes the text.
// Result channel: while out_empty is low, out_item holds the oldest token;
// raise out_pop to take it. A request gives zero, one or two tokens, and
// last_of_run marks the final token of each request.
// Structure: the front steps the lexer state one byte per cycle while in_full
// is low and forms the run of tokens for that request; a four-entry run
// queue decouples it from the output register, which hands out one token
// per cycle while out_pop is high. Each run passes through the queue into the
// output register. Throughput: at most one request and one token per cycle;
// a request that makes two tokens holds the output register for both, so
// long streams of such requests fill the queue and in_full paces the sender.
// Stall: while out_pop stays low, runs collect in the queue; once it is
// full, in_full rises and no further request is taken. Nothing is lost.
// Reset: rst_n low at a clock edge clears the lexer state and position
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
module command_keyword_tokenizer_top
  import ckt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  // Front to queue
  logic q_push;
  run_t q_wr_run;
  logic q_full;

  // Queue to back
  logic q_pop;
  logic q_empty;
  run_t q_rd_run;

  // Lexer state and token formation
  ckt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .in_full (in_full),
    .q_push  (q_push),
    .q_run   (q_wr_run)
  );

  // Hold runs while the receiver stalls
  ckt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_run (q_wr_run),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_run (q_rd_run)
  );

  // Advance tokens one at a time through the output register
  ckt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_run     (q_rd_run),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

@@ sim/command_keyword_tokenizer_top_tb.sv @@
// ----------------------------------------------------------------------------
// command_keyword_tokenizer_top_tb: self-checking bench of the tokenizer
// Feeds byte and end-of-text requests, predicts every token in a local lexer
// model and compares each popped token field by field, in order.
// ----------------------------------------------------------------------------
module command_keyword_tokenizer_top_tb;
  import ckt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Keyword token kinds, in the order of the keyword table below.
  localparam logic [3:0] KIND_PCMD     = 4'd1;
  localparam logic [3:0] KIND_REPORT   = 4'd2;
  localparam logic [3:0] KIND_QUIT     = 4'd3;
  localparam logic [3:0] KIND_SHUTDOWN = 4'd4;
  localparam logic [3:0] KIND_TRACK    = 4'd5;
  localparam logic [3:0] KIND_UNTRACK  = 4'd6;

  // First keyword spelled out as twelve ASCII bytes.
  localparam logic [95:0] PCMD_TEXT = 96'h70636c61726974795f636d64;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Timeout, far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {LX_IDLE, LX_KEYWORD, LX_PATH} lex_phase_e;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  command_keyword_tokenizer_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lexer model: its own copy of the state, stepped once per accepted request
  // --------------------------------------------------------------------------
  string      kw_text [6] = '{$sformatf("%s", PCMD_TEXT), "report", "quit", "shutdown",
                              "track", "untrack"};
  logic [3:0] kw_kind [6] = '{KIND_PCMD, KIND_REPORT, KIND_QUIT, KIND_SHUTDOWN,
                              KIND_TRACK, KIND_UNTRACK};

  lex_phase_e             lx_phase   = LX_IDLE;
  int                     lx_kw      = 0;   // zero-based keyword being matched
  int                     lx_matched = 0;   // tail bytes matched so far
  logic [OFFSET_BITS-1:0] lx_start   = '0;
  logic [OFFSET_BITS-1:0] lx_pos     = '0;

  out_item_t step_tokens [$];     // tokens of the request being modeled
  out_item_t pending_tokens [$];  // tokens predicted and not yet popped

  // Hold the position at its top value once reached.
  function automatic void bump_pos();
    if (lx_pos != '1) lx_pos++;
  endfunction

  function automatic void add_token(input logic [3:0] kind,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [OFFSET_BITS-1:0] len);
    out_item_t t;
    t.token_kind   = kind;
    t.token_start  = 16'(start);
    t.token_length = 16'(len);
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  // A byte seen between tokens: skip whitespace, or open or emit a token.
  function automatic void lex_idle_byte(input logic [7:0] b);
    if (b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR)) begin
      bump_pos();
      return;
    end
    lx_start = lx_pos;
    bump_pos();
    if (b == BYTE_NUL) begin
      add_token(KIND_END, lx_start, lx_pos - lx_start);
      return;
    end
    foreach (kw_text[k]) begin
      if (b == kw_text[k][0]) begin
        lx_phase   = LX_KEYWORD;
        lx_kw      = k;
        lx_matched = 0;
        return;
      end
    end
    if (b == PATH_MARK) begin
      lx_phase = LX_PATH;
      return;
    end
    add_token(KIND_UNSUP, lx_start, lx_pos - lx_start);
  endfunction

  function automatic void lex_step(input in_item_t it);
    step_tokens.delete();
    if (it.mode == MODE_END) begin
      if (lx_phase != LX_IDLE) add_token(KIND_UNSUP, lx_start, lx_pos - lx_start);
      lx_phase = LX_IDLE;
      add_token(KIND_END, lx_pos, '0);
    end else if (lx_phase == LX_KEYWORD) begin
      if (it.data_byte == kw_text[lx_kw][lx_matched + 1]) begin
        bump_pos();
        lx_matched++;
        if (lx_matched == kw_text[lx_kw].len() - 1) begin
          lx_phase = LX_IDLE;
          add_token(kw_kind[lx_kw], lx_start, lx_pos - lx_start);
        end
      end else begin
        // The matched prefix is dropped as unsupported; the byte starts over.
        lx_phase = LX_IDLE;
        add_token(KIND_UNSUP, lx_start, lx_pos - lx_start);
        lex_idle_byte(it.data_byte);
      end
    end else if (lx_phase == LX_PATH) begin
      bump_pos();
      if (it.data_byte == PATH_MARK) begin
        lx_phase = LX_IDLE;
        add_token(KIND_PATH, lx_start, lx_pos - lx_start);
      end
    end else begin
      lex_idle_byte(it.data_byte);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Flow control shared by both sides
  // --------------------------------------------------------------------------
  logic steady     = 1'b0;  // high: neither side idles
  int   stall_len  = 0;     // length of the next receiver hold-off
  int   stall_tag  = 0;     // bumped by a test to ask for a hold-off
  int   stall_seen = 0;
  int   hold_left  = 0;

  // Receiver: pop at random, or hold off for a counted stretch when asked.
  always @(posedge clk) begin
    if (stall_tag != stall_seen) begin
      stall_seen = stall_tag;
      hold_left  = stall_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  int mismatch_count = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Compare every popped token against the oldest prediction.
  always @(posedge clk) begin : take_token
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("token with none expected: kind %0d start %0d length %0d",
                                out_item.token_kind, out_item.token_start,
                                out_item.token_length));
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 16'(out_item.token_kind), 16'(want.token_kind));
        check_field("token_start", out_item.token_start, want.token_start);
        check_field("token_length", out_item.token_length, want.token_length);
        check_field("last_of_run", 16'(out_item.last_of_run), 16'(want.last_of_run));
      end
    end
  end

  // Kill the run if it never drains.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  // Offer one request, idling first at random, and hold it until taken.
  task automatic send_req(input logic mode, input logic [7:0] b);
    in_item_t it;
    it.mode      = mode;
    it.data_byte = b;
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    lex_step(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(MODE_BYTE, s[i]);
  endtask

  // Pause the sender until every predicted token has been popped.
  task automatic wait_for_tokens();
    in_push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    int n;
    n = $urandom_range(0, 5);
    return (n == 5) ? BYTE_SPACE : BYTE_TAB + 8'(n);
  endfunction

  function automatic logic [7:0] pick_path_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == PATH_MARK);
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Short hand-picked text: each token kind, whitespace, mismatches and
  // end of text while idle, inside a keyword and inside a path.
  task automatic test_directed();
    send_text("quit");
    send_req(MODE_BYTE, BYTE_NUL);
    send_text("@a@");
    send_req(MODE_BYTE, BYTE_SPACE);
    send_req(MODE_BYTE, BYTE_CR);
    send_req(MODE_BYTE, BYTE_TAB);
    send_text("tx");                   // mismatch, stray byte is its own token
    send_text("pp");                   // mismatch, byte reopens a keyword
    send_req(MODE_END, 8'hFF);         // end with a keyword pending
    send_req(MODE_END, 8'h00);         // end while idle
    send_text("@b");
    send_req(MODE_END, PATH_MARK);     // end inside an open path
    send_text("r@x@");                 // mismatch on an at-sign opens a path
    send_req(MODE_BYTE, 8'hFF);
    send_req(MODE_BYTE, 8'h08);        // just below the whitespace range
  endtask

  // Hold off the receiver while the sender alternates keyword first letters
  // with two-token mismatching bytes, so the queue fills and in_full pushes back.
  task automatic test_backpressure();
    int k;
    stall_len <= 300;
    stall_tag <= stall_tag + 1;
    repeat (20) begin
      k = $urandom_range(0, 5);
      send_req(MODE_BYTE, kw_text[k][0]);
      send_req(MODE_BYTE, "x");
    end
  endtask

  // Mostly well-formed keywords and paths with random content, mixed with
  // broken keywords, stray bytes, whitespace and end-of-text requests.
  task automatic test_random(input int n);
    int made;
    int pick;
    int k;
    int cut;
    int plen;
    made = 0;
    while (made < n) begin
      // Drop idling on both sides for one long stretch in the middle.
      steady <= (made >= n / 3) && (made < n / 3 + 300);
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 5);
      if (pick < 35) begin
        send_text(kw_text[k]);
        made += kw_text[k].len();
        if ($urandom_range(0, 1)) begin
          send_req(MODE_BYTE, pick_space());
          made++;
        end
      end else if (pick < 50) begin
        cut = $urandom_range(1, kw_text[k].len() - 1);
        send_text(kw_text[k].substr(0, cut - 1));
        send_req(MODE_BYTE, 8'($urandom_range(0, 255)));
        made += cut + 1;
      end else if (pick < 65) begin
        plen = $urandom_range(0, 8);
        send_req(MODE_BYTE, PATH_MARK);
        repeat (plen) send_req(MODE_BYTE, pick_path_byte());
        if ($urandom_range(0, 9) != 0) send_req(MODE_BYTE, PATH_MARK);
        else send_req(MODE_END, 8'($urandom_range(0, 255)));
        made += plen + 2;
      end else if (pick < 75) begin
        cut = $urandom_range(1, 4);
        repeat (cut) send_req(MODE_BYTE, pick_space());
        made += cut;
      end else if (pick < 80) begin
        send_req(MODE_BYTE, BYTE_NUL);
        made++;
      end else if (pick < 90) begin
        send_req(MODE_BYTE, 8'($urandom_range(0, 255)));
        made++;
      end else if (pick < 95) begin
        send_req(MODE_END, 8'($urandom_range(0, 255)));
        made++;
      end else begin
        cut = $urandom_range(1, kw_text[k].len() - 1);
        send_text(kw_text[k].substr(0, cut - 1));
        send_req(MODE_END, 8'($urandom_range(0, 255)));
        made += cut + 1;
      end
    end
    steady <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_for_tokens();
    test_backpressure();
    wait_for_tokens();
    test_random(1180);
    wait_for_tokens();

    // Leave room for any stray token behind the last expected one.
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
